// File: design/mrb_pkg.sv
// Shared types, constants and helpers for the message ring buffer unit.
// Depends on nothing; every other design file takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package mrb_pkg;

  // Number of byte entries in the ring.
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned PTR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Result status codes.
  localparam logic [2:0] ST_PENDING  = 3'd0;
  localparam logic [2:0] ST_ACCEPTED = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_READ     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // Request codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] push_byte;
  } mrb_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       pop_byte;
    logic             end_of_message;
    logic [CNT_W-1:0] accepted_length;
    logic [CNT_W-1:0] space_free;
    logic             data_available;
  } mrb_out_t;

  // Access request from the controller to the byte store.
  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } mrb_mem_req_t;

  // Advance a ring pointer, wrapping after the last entry.
  function automatic logic [PTR_W-1:0] next_index(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/mrb_store.sv
// Byte store of the message ring buffer: one write port, one read port,
// registered read data. Depends on mrb_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module mrb_store (
  input  wire logic                clk,
  input  wire mrb_pkg::mrb_mem_req_t mem_req,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [mrb_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/mrb_ctrl.sv
// Pointer and count control of the message ring buffer, with the result register.
// Depends on mrb_pkg; drives the byte store through an mrb_mem_req_t.
`timescale 1ns / 1ps
`default_nettype none

module mrb_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire mrb_pkg::mrb_in_t      in_item,
  output logic                       out_strobe,
  output mrb_pkg::mrb_out_t          out_item,
  output mrb_pkg::mrb_mem_req_t      mem_req,
  input  wire logic [7:0]            rd_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                      st_r, st_nxt;
  logic [mrb_pkg::PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mrb_pkg::PTR_W-1:0]   cm_ptr_r, cm_ptr_nxt;
  logic [mrb_pkg::PTR_W-1:0]   tn_ptr_r, tn_ptr_nxt;
  logic [mrb_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [mrb_pkg::CNT_W-1:0]   pend_r, pend_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        out_strobe_r, out_strobe_nxt;
  mrb_pkg::mrb_out_t           out_item_r, out_item_nxt;

  logic [mrb_pkg::CNT_W-1:0]   space_now;
  logic [mrb_pkg::CNT_W-1:0]   acc_len;
  logic                        fits;

  assign space_now = mrb_pkg::CAP_CNT - cnt_r;
  assign fits      = (pend_r < space_now) && !ovf_r;
  assign acc_len   = pend_r + mrb_pkg::CNT_W'(1);

  always_comb begin
    st_nxt         = st_r;
    rd_ptr_nxt     = rd_ptr_r;
    cm_ptr_nxt     = cm_ptr_r;
    tn_ptr_nxt     = tn_ptr_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    ovf_nxt        = ovf_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_req        = '0;

    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          out_item_nxt.pop_byte        = 8'd0;
          out_item_nxt.end_of_message  = 1'b0;
          out_item_nxt.accepted_length = '0;
          out_item_nxt.space_free      = space_now;
          out_item_nxt.data_available  = (cnt_r != '0);
          if (in_item.req_type == mrb_pkg::REQ_PUSH) begin
            out_strobe_nxt = 1'b1;
            if (in_item.push_byte != 8'd0) begin
              out_item_nxt.status = mrb_pkg::ST_PENDING;
              if (fits) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = tn_ptr_r;
                mem_req.wr_data = in_item.push_byte;
                tn_ptr_nxt      = mrb_pkg::next_index(tn_ptr_r);
                pend_nxt        = pend_r + mrb_pkg::CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end else begin
              if (fits) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = tn_ptr_r;
                mem_req.wr_data = 8'd0;
                tn_ptr_nxt      = mrb_pkg::next_index(tn_ptr_r);
                cm_ptr_nxt      = mrb_pkg::next_index(tn_ptr_r);
                cnt_nxt         = cnt_r + acc_len;
                out_item_nxt.status          = mrb_pkg::ST_ACCEPTED;
                out_item_nxt.accepted_length = acc_len;
                out_item_nxt.space_free      = mrb_pkg::CAP_CNT - (cnt_r + acc_len);
                out_item_nxt.data_available  = 1'b1;
              end else begin
                tn_ptr_nxt          = cm_ptr_r;
                out_item_nxt.status = mrb_pkg::ST_REJECTED;
              end
              pend_nxt = '0;
              ovf_nxt  = 1'b0;
            end
          end else begin
            if (cnt_r == '0) begin
              out_strobe_nxt      = 1'b1;
              out_item_nxt.status = mrb_pkg::ST_EMPTY;
            end else begin
              // The byte arrives from the store in the next cycle.
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = rd_ptr_r;
              rd_ptr_nxt      = mrb_pkg::next_index(rd_ptr_r);
              cnt_nxt         = cnt_r - mrb_pkg::CNT_W'(1);
              st_nxt          = S_READ;
            end
          end
        end
      end
      S_READ: begin
        out_strobe_nxt               = 1'b1;
        out_item_nxt.status          = mrb_pkg::ST_READ;
        out_item_nxt.pop_byte        = rd_data;
        out_item_nxt.end_of_message  = (rd_data == 8'd0);
        out_item_nxt.accepted_length = '0;
        out_item_nxt.space_free      = space_now;
        out_item_nxt.data_available  = (cnt_r != '0);
        st_nxt                       = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      rd_ptr_r     <= '0;
      cm_ptr_r     <= '0;
      tn_ptr_r     <= '0;
      cnt_r        <= '0;
      pend_r       <= '0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      cm_ptr_r     <= cm_ptr_nxt;
      tn_ptr_r     <= tn_ptr_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign busy       = (st_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

// File: design/message_ring_buffer_unit.sv
// A push or a pop of an empty buffer gives its result through the result register alone;
// a pop of a committed byte passes the store's read register, then the result register.
// Throughput: one push per cycle while busy is low; a pop of data holds busy for one cycle.
// Reset (synchronous, rst_n low) clears all pointers, counts and flags at once; the byte
// store keeps its contents and needs no clearing pass. The receiver cannot stall results.
// Top level of the message ring buffer; depends on mrb_pkg, mrb_ctrl and mrb_store.
`timescale 1ns / 1ps
`default_nettype none

module message_ring_buffer_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire mrb_pkg::mrb_in_t in_item,
  output logic                  out_strobe,
  output mrb_pkg::mrb_out_t     out_item
);

  // Requests from the controller to the byte store. Writes always land in the
  // tentative region ahead of the commit pointer, and reads only touch committed
  // entries, so a read never meets a write to the same entry in flight.
  mrb_pkg::mrb_mem_req_t mem_req;

  // Registered read data of the store, valid in the cycle after a read request.
  logic [7:0] rd_data;

  // The controller holds the ring pointers, the committed count, the length of the
  // message being assembled and its overflow flag. It also owns the result register,
  // so each result is shown for exactly one cycle with out_strobe high.
  mrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .mem_req    (mem_req),
    .rd_data    (rd_data)
  );

  // Single-port-write, single-port-read byte store with registered read data.
  mrb_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
